// ===== rtl/core/rhd_pkg.sv =====
// Package for the response deframer: phase encoding, per-response context,
// result record, register indexes and framing constants.
// No dependencies.
package rhd_pkg;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_MARKER  = 4'b0010,
        PH_HEADER  = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t       phase;
        logic [3:0]   header_count;
        logic [63:0]  header_shift;
        logic         magic_ok;
        logic [31:0]  remaining_count;
        logic [31:0]  total_count;
        logic         last_fragment;
    } ctx_t;

    typedef struct packed {
        logic         valid;
        logic [7:0]   out_byte;
        logic         byte_valid;
        logic         last;
        logic         status;
    } res_t;

    localparam ctx_t CTX_RESET = '{
        phase:           PH_IDLE,
        header_count:    4'd0,
        header_shift:    64'd0,
        magic_ok:        1'b0,
        remaining_count: 32'd0,
        total_count:     32'd0,
        last_fragment:   1'b0
    };

    // Configuration register indexes
    localparam logic CFG_FRAMING_MODE   = 1'b0;
    localparam logic CFG_MAX_FRAME_SIZE = 1'b1;

    localparam logic [31:0] MAX_FRAME_RESET = 32'd1048576;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_HEADER = 1'b1;

    localparam logic [7:0] MAGIC0       = 8'h48;
    localparam logic [7:0] MAGIC1       = 8'h53;
    localparam logic [3:0] LEN_OFFSET   = 4'd8;
    localparam logic [3:0] HDR_LAST_POS = 4'd15;
    localparam logic [3:0] MARKER_BYTES = 4'd4;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

endpackage

// ===== rtl/core/rhd_step.sv =====
// Per-byte step of the response deframer: next context and result for one
// transfer, given the current context and configuration. Uses rhd_pkg.
module rhd_step (
    input  rhd_pkg::ctx_t  ctx,
    input  logic           op,
    input  logic [7:0]     data_byte,
    input  logic           framing_mode,
    input  logic [31:0]    max_frame_size,
    output rhd_pkg::ctx_t  ctx_next,
    output rhd_pkg::res_t  res
);
    import rhd_pkg::*;

    logic [63:0] shifted;
    logic [3:0]  cnt_inc;
    logic [30:0] frag_len;
    logic [32:0] frag_sum;
    logic        frag_too_big;
    logic        magic_now;
    logic        hdr_bad;
    logic [31:0] rem_dec;
    logic [31:0] tot_inc;

    assign shifted  = {ctx.header_shift[55:0], data_byte};
    assign cnt_inc  = ctx.header_count + 4'd1;
    assign frag_len = shifted[30:0];
    // Total plus fragment length against the limit, with no wraparound
    assign frag_sum     = {1'b0, ctx.total_count} + {2'b00, frag_len};
    assign frag_too_big = frag_sum > {1'b0, max_frame_size};

    always_comb
    begin
        if (ctx.header_count == 4'd0)
            magic_now = (data_byte == MAGIC0);
        else if (ctx.header_count == 4'd1)
            magic_now = ctx.magic_ok && (data_byte == MAGIC1);
        else
            magic_now = ctx.magic_ok;
    end

    // On the final header byte the length field already holds that byte
    assign hdr_bad = !magic_now || (shifted[63:32] != 32'd0)
                     || (shifted[31:0] > max_frame_size);

    assign rem_dec = ctx.remaining_count - 32'd1;
    assign tot_inc = ctx.total_count + 32'd1;

    always_comb
    begin
        ctx_next = ctx;
        res      = '0;
        if (op)
        begin
            ctx_next       = CTX_RESET;
            ctx_next.phase = (framing_mode == MODE_HEADER) ? PH_HEADER : PH_MARKER;
        end
        else
        begin
            case (ctx.phase)
                PH_MARKER:
                begin
                    ctx_next.header_shift = shifted;
                    ctx_next.header_count = cnt_inc;
                    if (!(cnt_inc < MARKER_BYTES))
                    begin
                        ctx_next.header_count = 4'd0;
                        if (frag_too_big)
                        begin
                            ctx_next.phase = PH_IDLE;
                            res.valid      = 1'b1;
                            res.last       = 1'b1;
                            res.status     = STATUS_ERR;
                        end
                        else
                        begin
                            ctx_next.last_fragment = shifted[31];
                            if (frag_len == 31'd0)
                            begin
                                // empty fragment: end only if flagged last
                                if (shifted[31])
                                begin
                                    ctx_next.phase = PH_IDLE;
                                    res.valid      = 1'b1;
                                    res.last       = 1'b1;
                                    res.status     = STATUS_OK;
                                end
                            end
                            else
                            begin
                                ctx_next.remaining_count = {1'b0, frag_len};
                                ctx_next.phase           = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_HEADER:
                begin
                    ctx_next.magic_ok = magic_now;
                    if (!(ctx.header_count < LEN_OFFSET))
                        ctx_next.header_shift = shifted;
                    if (ctx.header_count < HDR_LAST_POS)
                    begin
                        ctx_next.header_count = cnt_inc;
                        res.valid      = 1'b1;
                        res.out_byte   = data_byte;
                        res.byte_valid = 1'b1;
                    end
                    else
                    begin
                        ctx_next.header_count = 4'd0;
                        res.valid = 1'b1;
                        if (hdr_bad)
                        begin
                            ctx_next.phase = PH_IDLE;
                            res.last       = 1'b1;
                            res.status     = STATUS_ERR;
                        end
                        else
                        begin
                            ctx_next.remaining_count = shifted[31:0];
                            ctx_next.last_fragment   = 1'b1;
                            res.out_byte   = data_byte;
                            res.byte_valid = 1'b1;
                            if (shifted[31:0] == 32'd0)
                            begin
                                ctx_next.phase = PH_IDLE;
                                res.last       = 1'b1;
                            end
                            else
                            begin
                                ctx_next.phase = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    ctx_next.remaining_count = rem_dec;
                    ctx_next.total_count     = tot_inc;
                    res.valid      = 1'b1;
                    res.out_byte   = data_byte;
                    res.byte_valid = 1'b1;
                    if (rem_dec == 32'd0)
                    begin
                        if (ctx.last_fragment)
                        begin
                            ctx_next.phase = PH_IDLE;
                            res.last       = 1'b1;
                        end
                        else
                        begin
                            ctx_next.phase        = PH_MARKER;
                            ctx_next.header_count = 4'd0;
                        end
                    end
                end
                default:
                begin
                    // idle: drop the byte
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/rpc_hislip_response_deframer.sv =====
// Top level of the response deframer: config registers, input register,
// context register and output register around rhd_step. Uses rhd_pkg.
//
// An input transfer is held in the input register, then one step moves its result
// into the output register, from which the earliest output transfer is made.
// Throughput: one byte per cycle. While a result waits, transfers that make no
// result still advance; one that makes a result holds in the input register
// and stalls the input until the waiting result is taken.
// Reset clears handshake state, the context and the config registers
// (framing_mode 0, max_frame_size 1048576).
module rpc_hislip_response_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        last,
    output logic        status,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);
    import rhd_pkg::*;

    logic        framing_mode_reg;
    logic [31:0] max_frame_size_reg;

    logic        s1_valid_reg;
    logic        s1_op_reg;
    logic [7:0]  s1_byte_reg;

    ctx_t        ctx_reg;
    ctx_t        ctx_next;
    res_t        res;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        byte_valid_reg;
    logic        last_reg;
    logic        status_reg;

    logic        out_free;
    logic        s1_fire;
    logic        in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            framing_mode_reg   <= MODE_RECORD;
            max_frame_size_reg <= MAX_FRAME_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAMING_MODE:   framing_mode_reg   <= cfg_wdata[0];
                CFG_MAX_FRAME_SIZE: max_frame_size_reg <= cfg_wdata;
                default:            framing_mode_reg   <= framing_mode_reg;
            endcase
        end
    end

    rhd_step u_step (
        .ctx            (ctx_reg),
        .op             (s1_op_reg),
        .data_byte      (s1_byte_reg),
        .framing_mode   (framing_mode_reg),
        .max_frame_size (max_frame_size_reg),
        .ctx_next       (ctx_next),
        .res            (res)
    );

    assign out_free = !out_valid_reg || out_ready;
    // Advance the held transfer unless its result has nowhere to go
    assign s1_fire  = s1_valid_reg && (!res.valid || out_free);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg   <= op;
            s1_byte_reg <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctx_reg <= CTX_RESET;
        else if (s1_fire)
            ctx_reg <= ctx_next;
    end

    always_comb
    begin
        if (s1_fire && res.valid)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && res.valid)
        begin
            out_byte_reg   <= res.out_byte;
            byte_valid_reg <= res.byte_valid;
            last_reg       <= res.last;
            status_reg     <= res.status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign last       = last_reg;
    assign status     = status_reg;

    // An error always closes the response
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg |-> last_reg)
        else $error("error result without last");

    // A result that carries no byte only ever ends a response
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !byte_valid_reg |-> last_reg)
        else $error("byte-less result not marked last");

    // Ending a response leaves the context idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && res.valid && res.last |=> ctx_reg.phase == PH_IDLE)
        else $error("context not idle after last result");

    // Marker byte count never reaches a full marker between transfers
    a_marker_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.phase == PH_MARKER |-> ctx_reg.header_count < MARKER_BYTES)
        else $error("marker byte count out of range");

endmodule
